// ===== src/tkd_pkg.sv =====
// ----------------------------------------------------------------------------
// tkd_pkg: shared types and constants for the terminal key decoder
// Transaction payloads, escape tracker phases, key bit positions and the
// hold countdown width.
// ----------------------------------------------------------------------------
package tkd_pkg;

    // Width of each per-key hold countdown
    localparam int HOLD_BITS    = 10;
    localparam int HOLD_CFG_W   = 10;
    localparam int CFG_DATA_W   = 10;
    localparam int CFG_INDEX_W  = 1;

    // Register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_RAW_MODE   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_TICKS = 1'd1;

    localparam logic                  RAW_MODE_RESET   = 1'b1;
    localparam logic [HOLD_CFG_W-1:0] HOLD_TICKS_RESET = 10'd150;

    // Input transaction kinds
    localparam logic [1:0] KIND_BYTE      = 2'd0;
    localparam logic [1:0] KIND_TICK      = 2'd1;
    localparam logic [1:0] KIND_BURST_END = 2'd2;
    localparam logic [1:0] KIND_HOST_MASK = 2'd3;

    // Byte values
    localparam logic [7:0] BYTE_ESC     = 8'h1B;
    localparam logic [7:0] BYTE_CTRL_D  = 8'h04;
    localparam logic [7:0] FINAL_LOW    = 8'h40;
    localparam logic [7:0] FINAL_HIGH   = 8'h7E;
    localparam logic [7:0] BYTE_CSI     = 8'h5B; // '['
    localparam logic [7:0] BYTE_FIN_UP  = 8'h41; // 'A'
    localparam logic [7:0] BYTE_FIN_DN  = 8'h42; // 'B'
    localparam logic [7:0] BYTE_W_LO    = 8'h77;
    localparam logic [7:0] BYTE_W_UP    = 8'h57;
    localparam logic [7:0] BYTE_S_LO    = 8'h73;
    localparam logic [7:0] BYTE_S_UP    = 8'h53;
    localparam logic [7:0] BYTE_SPACE   = 8'h20;
    localparam logic [7:0] BYTE_LF      = 8'h0A;
    localparam logic [7:0] BYTE_CR      = 8'h0D;

    // Key bit positions in the mask
    localparam int KEY_W     = 0;
    localparam int KEY_S     = 1;
    localparam int KEY_UP    = 2;
    localparam int KEY_DOWN  = 3;
    localparam int KEY_SPACE = 4;
    localparam int KEY_ESC   = 5;
    localparam int KEY_ENTER = 6;
    localparam int KEY_ANY   = 7;
    localparam int NUM_KEYS  = 8;

    typedef enum logic [1:0] {
        ESC_NORMAL  = 2'd0,
        ESC_SAW_ESC = 2'd1,
        ESC_SAW_CSI = 2'd2
    } t_esc_phase;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] key_mask;
        logic       text_valid;
        logic [7:0] text_byte;
        logic       console_eof;
    } t_out_item;

    // Decoder result for one transaction
    typedef struct packed {
        logic [NUM_KEYS-1:0] load_keys;
        logic                text_valid;
        logic                eof_next;
    } t_dec_res;

    // Control for the hold countdown bank
    typedef struct packed {
        logic                tick;
        logic                host_wr;
        logic [7:0]          host_bits;
        logic [NUM_KEYS-1:0] load_keys;
    } t_hold_ctrl;

    // Hold time as loaded into a countdown, saturated at the countdown width
    function automatic logic [HOLD_BITS-1:0] hold_load(input logic [HOLD_CFG_W-1:0] ticks);
        logic [31:0] wide;
        wide = 32'(ticks);
        if ((wide >> HOLD_BITS) != 32'd0) begin
            return '1;
        end
        return HOLD_BITS'(wide);
    endfunction

endpackage

// ===== src/tkd_esc_decode.sv =====
// ----------------------------------------------------------------------------
// tkd_esc_decode: escape tracker and byte classifier
// Holds the escape phase and the end-of-file flag, and turns each transaction
// into key hits, a text flag and the next end-of-file state.
// ----------------------------------------------------------------------------
module tkd_esc_decode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  tkd_pkg::t_in_item i_item,
    input  logic              i_raw_mode,
    output tkd_pkg::t_dec_res o_res
);
    import tkd_pkg::*;

    t_esc_phase          r_phase;
    t_esc_phase          n_phase;
    logic                r_eof;
    logic                n_eof;
    logic [NUM_KEYS-1:0] keys;
    logic                text_valid;
    logic                plain_path;
    logic [7:0]          ch;

    assign ch = i_item.data_byte;

    // Work out the next phase, hits and text for this transaction
    always_comb begin
        n_phase    = r_phase;
        n_eof      = r_eof;
        keys       = '0;
        text_valid = 1'b0;
        plain_path = 1'b0;
        if (i_item.kind == KIND_BYTE && !r_eof) begin
            unique case (r_phase)
                ESC_SAW_ESC: begin
                    if (ch == BYTE_CSI) begin
                        n_phase = ESC_SAW_CSI;
                    end else begin
                        // lone escape: count it, then treat this byte normally
                        n_phase        = ESC_NORMAL;
                        keys[KEY_ESC]  = 1'b1;
                        keys[KEY_ANY]  = 1'b1;
                        plain_path     = 1'b1;
                    end
                end
                ESC_SAW_CSI: begin
                    // swallow parameter bytes until a final byte
                    if (ch == BYTE_FIN_UP) begin
                        keys[KEY_UP]  = 1'b1;
                        keys[KEY_ANY] = 1'b1;
                        n_phase       = ESC_NORMAL;
                    end else if (ch == BYTE_FIN_DN) begin
                        keys[KEY_DOWN] = 1'b1;
                        keys[KEY_ANY]  = 1'b1;
                        n_phase        = ESC_NORMAL;
                    end else if (ch >= FINAL_LOW && ch <= FINAL_HIGH) begin
                        keys[KEY_ANY] = 1'b1;
                        n_phase       = ESC_NORMAL;
                    end
                end
                default: begin
                    n_phase    = ESC_NORMAL;
                    plain_path = 1'b1;
                end
            endcase
            if (plain_path) begin
                if (ch == BYTE_ESC) begin
                    n_phase = ESC_SAW_ESC;
                end else if (i_raw_mode && ch == BYTE_CTRL_D) begin
                    n_eof = 1'b1;
                end else begin
                    text_valid    = 1'b1;
                    keys[KEY_ANY] = 1'b1;
                    if (ch == BYTE_W_LO || ch == BYTE_W_UP) begin
                        keys[KEY_W] = 1'b1;
                    end else if (ch == BYTE_S_LO || ch == BYTE_S_UP) begin
                        keys[KEY_S] = 1'b1;
                    end else if (ch == BYTE_SPACE) begin
                        keys[KEY_SPACE] = 1'b1;
                    end else if (ch == BYTE_LF || ch == BYTE_CR) begin
                        keys[KEY_ENTER] = 1'b1;
                    end
                end
            end
        end else if (i_item.kind == KIND_BURST_END && !r_eof && r_phase == ESC_SAW_ESC) begin
            // end of burst after a lone escape
            n_phase       = ESC_NORMAL;
            keys[KEY_ESC] = 1'b1;
            keys[KEY_ANY] = 1'b1;
        end
    end

    always_comb begin
        o_res.load_keys  = keys;
        o_res.text_valid = text_valid;
        o_res.eof_next   = n_eof;
    end

    // Advance tracker state on each processed transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ESC_NORMAL;
            r_eof   <= 1'b0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_eof   <= n_eof;
        end
    end

endmodule

// ===== src/tkd_hold_bank.sv =====
// ----------------------------------------------------------------------------
// tkd_hold_bank: per-key hold countdowns and host key mask
// Loads countdowns on hits, decrements them on ticks and forms the key mask
// from the updated state.
// ----------------------------------------------------------------------------
module tkd_hold_bank (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_fire,
    input  tkd_pkg::t_hold_ctrl            i_ctrl,
    input  logic [tkd_pkg::HOLD_BITS-1:0]  i_load_value,
    output logic [7:0]                     o_key_mask
);
    import tkd_pkg::*;

    logic [HOLD_BITS-1:0] r_remain [NUM_KEYS];
    logic [HOLD_BITS-1:0] n_remain [NUM_KEYS];
    logic [7:0]           r_host;
    logic [7:0]           n_host;
    logic [NUM_KEYS-1:0]  held;

    // Next countdown values and held flags
    always_comb begin
        for (int b = 0; b < NUM_KEYS; b++) begin
            n_remain[b] = r_remain[b];
            if (i_ctrl.load_keys[b]) begin
                n_remain[b] = i_load_value;
            end else if (i_ctrl.tick && r_remain[b] != '0) begin
                n_remain[b] = r_remain[b] - HOLD_BITS'(1);
            end
            held[b] = (n_remain[b] != '0);
        end
        n_host = i_ctrl.host_wr ? i_ctrl.host_bits : r_host;
    end

    assign o_key_mask = n_host | held;

    // Hold countdowns and host mask
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < NUM_KEYS; b++) begin
                r_remain[b] <= '0;
            end
            r_host <= '0;
        end else if (i_fire) begin
            for (int b = 0; b < NUM_KEYS; b++) begin
                r_remain[b] <= n_remain[b];
            end
            r_host <= n_host;
        end
    end

endmodule

// ===== src/terminal_key_decoder_core.sv =====
// ----------------------------------------------------------------------------
// terminal_key_decoder_core: terminal byte to key mask and text decoder
// Input register, single-pass decode and countdown update, result register.
// ----------------------------------------------------------------------------
// Flow: an accepted transaction waits in the input register, is decoded and
// then lands in the result register; a result that is not taken stalls it.
// Throughput: one transaction per cycle while results are taken; the decode and
// countdown update are one pass between the input register and the result register.
// Reset: synchronous, active low; clears tracker, countdowns, host mask, EOF
// flag and both pipeline valids; raw mode to 1 and hold time to 150 ticks.
module terminal_key_decoder_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  tkd_pkg::t_in_item                i_in,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output tkd_pkg::t_out_item               o_out,
    input  logic                             i_cfg_we,
    input  logic [tkd_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [tkd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import tkd_pkg::*;

    logic                  r_raw_mode;
    logic [HOLD_CFG_W-1:0] r_hold_ticks;
    logic                  r_in_valid;
    t_in_item              r_in;
    logic                  r_out_valid;
    t_out_item             r_out;
    logic                  fire;
    t_dec_res              dec_res;
    t_hold_ctrl            hold_ctrl;
    logic [7:0]            key_mask;
    logic [HOLD_BITS-1:0]  load_value;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_mode   <= RAW_MODE_RESET;
            r_hold_ticks <= HOLD_TICKS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RAW_MODE:   r_raw_mode   <= i_cfg_data[0];
                CFG_HOLD_TICKS: r_hold_ticks <= i_cfg_data[HOLD_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Process the held transaction when the result register can take it
    assign fire       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
    end

    tkd_esc_decode u_esc_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_item     (r_in),
        .i_raw_mode (r_raw_mode),
        .o_res      (dec_res)
    );

    assign load_value = hold_load(r_hold_ticks);

    always_comb begin
        hold_ctrl.tick      = (r_in.kind == KIND_TICK);
        hold_ctrl.host_wr   = (r_in.kind == KIND_HOST_MASK);
        hold_ctrl.host_bits = r_in.data_byte;
        hold_ctrl.load_keys = dec_res.load_keys;
    end

    tkd_hold_bank u_hold_bank (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_ctrl       (hold_ctrl),
        .i_load_value (load_value),
        .o_key_mask   (key_mask)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out.key_mask    <= key_mask;
            r_out.text_valid  <= dec_res.text_valid;
            r_out.text_byte   <= dec_res.text_valid ? r_in.data_byte : 8'd0;
            r_out.console_eof <= dec_res.eof_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
